[rtl/crse_pkg.sv]
package crse_pkg;

  localparam int unsigned MAX_POINTS_DEF = 16;

  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z    = 4'd3;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_POS   = 2'd1;
  localparam logic [1:0] OP_SLOPE = 2'd2;

  localparam int WGT_W = 35;
  localparam int SEG_W = 5;
  localparam int FIFO_DEPTH = 2;

  typedef logic signed [WGT_W-1:0] wgt_t;

  typedef struct packed {
    logic              is_wr;
    logic              is_slope;
    logic              wr_ok;
    logic [3:0]        wr_idx;
    logic [31:0]       px;
    logic [31:0]       py;
    logic [31:0]       pz;
    logic [SEG_W-1:0]  seg;
    wgt_t              w0;
    wgt_t              w1;
    wgt_t              w2;
    wgt_t              w3;
  } cmd_t;

endpackage

[rtl/crse_front.sv]
module crse_front #(
  parameter int unsigned MAX_POINTS = crse_pkg::MAX_POINTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [1:0]            in_opcode,
  input  logic [3:0]            in_point_index,
  input  logic signed [31:0]    in_point_x,
  input  logic signed [31:0]    in_point_y,
  input  logic signed [31:0]    in_point_z,
  input  logic [16:0]           in_curve_param,
  input  logic [4:0]            point_count,
  input  logic                  q_full,
  output logic                  q_push,
  output crse_pkg::cmd_t        q_data
);
  import crse_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SEG  = 3'd1;
  localparam logic [2:0] S_SQ   = 3'd2;
  localparam logic [2:0] S_CB   = 3'd3;
  localparam logic [2:0] S_WT   = 3'd4;
  localparam logic [2:0] S_PUSH = 3'd5;

  logic [2:0]   st_r, st_nxt;
  cmd_t         cmd_r;
  logic [16:0]  t_r;
  logic [16:0]  lt_r;
  logic [33:0]  lt2_r;
  logic [50:0]  lt3_r;

  logic [4:0]   n_c;
  logic [4:0]   segs;
  logic [21:0]  u;
  logic [5:0]   segq;
  logic [4:0]   seg_c;
  logic [16:0]  lt_c;
  logic signed [55:0] a, b, c, one;
  logic signed [55:0] nw0, nw1, nw2, nw3;
  logic signed [55:0] half;

  // segment and local parameter
  always_comb begin
    n_c = point_count;
    if (point_count < 5'd4) n_c = 5'd4;
    else if (32'(point_count) > 32'(MAX_POINTS)) n_c = 5'(MAX_POINTS);
    segs = n_c - 5'd3;
    u = 22'(t_r) * 22'(segs);
    segq = u[21:16];
    seg_c = (segq > {1'b0, segs - 5'd1}) ? segs - 5'd1 : segq[4:0];
    lt_c = 17'(u - 22'({seg_c, 16'b0}));
  end

  // blend weights, twice the weight in q.48, then rounded to q.32
  always_comb begin
    a    = 56'(lt3_r);
    b    = 56'({lt2_r, 16'b0});
    c    = 56'({lt_r, 32'b0});
    one  = 56'sd1 <<< 48;
    half = 56'sd65536;
    if (cmd_r.is_slope) begin
      nw0 = -3 * b + 4 * c - one;
      nw1 = 9 * b - 10 * c;
      nw2 = -9 * b + 8 * c + one;
      nw3 = 3 * b - 2 * c;
    end else begin
      nw0 = -a + 2 * b - c;
      nw1 = 3 * a - 5 * b + 2 * one;
      nw2 = -3 * a + 4 * b + c;
      nw3 = a - b;
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: begin
        if (in_push) begin
          if (in_opcode == OP_WRITE) st_nxt = S_PUSH;
          else if (in_opcode == OP_POS || in_opcode == OP_SLOPE) st_nxt = S_SEG;
        end
      end
      S_SEG:  st_nxt = S_SQ;
      S_SQ:   st_nxt = S_CB;
      S_CB:   st_nxt = S_WT;
      S_WT:   st_nxt = S_PUSH;
      S_PUSH: if (!q_full) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: begin
        cmd_r.is_wr    <= (in_opcode == OP_WRITE);
        cmd_r.is_slope <= (in_opcode == OP_SLOPE);
        cmd_r.wr_ok    <= (32'(in_point_index) < 32'(MAX_POINTS));
        cmd_r.wr_idx   <= in_point_index;
        cmd_r.px       <= in_point_x;
        cmd_r.py       <= in_point_y;
        cmd_r.pz       <= in_point_z;
        t_r <= (in_curve_param > 17'd65536) ? 17'd65536 : in_curve_param;
      end
      S_SEG: begin
        cmd_r.seg <= seg_c;
        lt_r      <= lt_c;
      end
      S_SQ: lt2_r <= 34'(lt_r) * 34'(lt_r);
      S_CB: lt3_r <= 51'(lt2_r) * 51'(lt_r);
      S_WT: begin
        cmd_r.w0 <= WGT_W'((nw0 + half) >>> 17);
        cmd_r.w1 <= WGT_W'((nw1 + half) >>> 17);
        cmd_r.w2 <= WGT_W'((nw2 + half) >>> 17);
        cmd_r.w3 <= WGT_W'((nw3 + half) >>> 17);
      end
      default: ;
    endcase
  end

  assign in_full = (st_r != S_IDLE);
  assign q_push  = (st_r == S_PUSH) && !q_full;
  assign q_data  = cmd_r;

endmodule

[rtl/crse_fifo.sv]
module crse_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  crse_pkg::cmd_t  push_data,
  output logic            full,
  input  logic            pop,
  output crse_pkg::cmd_t  pop_data,
  output logic            empty
);
  import crse_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);

  cmd_t          ent_r [FIFO_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_data;
  end

  assign pop_data = ent_r[rp_r];
  assign full     = (cnt_r == (PW+1)'(FIFO_DEPTH));
  assign empty    = (cnt_r == '0);

endmodule

[rtl/crse_back.sv]
module crse_back #(
  parameter int unsigned MAX_POINTS = crse_pkg::MAX_POINTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  output logic                q_pop,
  input  crse_pkg::cmd_t      q_data,
  input  logic signed [31:0]  offset_x,
  input  logic signed [31:0]  offset_y,
  input  logic signed [31:0]  offset_z,
  output logic                out_empty,
  input  logic                out_pop,
  output logic signed [31:0]  out_result_x,
  output logic signed [31:0]  out_result_y,
  output logic signed [31:0]  out_result_z,
  output logic                out_clipped,
  output logic                out_is_slope
);
  import crse_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_WR   = 3'd1;
  localparam logic [2:0] B_RD   = 3'd2;
  localparam logic [2:0] B_MUL  = 3'd3;
  localparam logic [2:0] B_ACC  = 3'd4;
  localparam logic [2:0] B_FIN  = 3'd5;
  localparam logic [2:0] B_DONE = 3'd6;

  logic [31:0] mem_x [MAX_POINTS];
  logic [31:0] mem_y [MAX_POINTS];
  logic [31:0] mem_z [MAX_POINTS];

  logic [2:0]   st_r, st_nxt;
  cmd_t         cur_r;
  logic [1:0]   k_r;
  logic [1:0]   crd_r;
  logic [31:0]  rd_x_r, rd_y_r, rd_z_r;
  logic signed [51:0] prod_hi_r, prod_lo_r;
  logic signed [71:0] acc_r;
  logic signed [31:0] res_x_r, res_y_r, res_z_r;
  logic         clip_r;
  logic         out_vld_r;
  logic signed [31:0] out_x_r, out_y_r, out_z_r;
  logic         out_clip_r, out_slope_r;

  logic [31:0]  addr_full;
  logic [31:0]  wa_full;
  logic [AW-1:0] rd_addr, wr_addr;
  logic signed [31:0] rd_sel, off_sel;
  logic signed [32:0] p;
  logic signed [16:0] hi;
  logic signed [16:0] lo;
  wgt_t         w_sel;
  logic signed [39:0] r;
  logic signed [31:0] r_sat;
  logic         r_clip;
  logic         load;

  assign addr_full = 32'(cur_r.seg) + 32'(k_r);
  assign rd_addr   = addr_full[AW-1:0];
  assign wa_full   = 32'(cur_r.wr_idx);
  assign wr_addr   = wa_full[AW-1:0];

  always_ff @(posedge clk) begin
    if (st_r == B_WR && cur_r.wr_ok) begin
      mem_x[wr_addr] <= cur_r.px;
      mem_y[wr_addr] <= cur_r.py;
      mem_z[wr_addr] <= cur_r.pz;
    end
    rd_x_r <= mem_x[rd_addr];
    rd_y_r <= mem_y[rd_addr];
    rd_z_r <= mem_z[rd_addr];
  end

  always_comb begin
    case (crd_r)
      2'd0: begin
        rd_sel  = rd_x_r;
        off_sel = offset_x;
      end
      2'd1: begin
        rd_sel  = rd_y_r;
        off_sel = offset_y;
      end
      default: begin
        rd_sel  = rd_z_r;
        off_sel = offset_z;
      end
    endcase
    case (k_r)
      2'd0:    w_sel = cur_r.w0;
      2'd1:    w_sel = cur_r.w1;
      2'd2:    w_sel = cur_r.w2;
      default: w_sel = cur_r.w3;
    endcase
    p  = 33'(rd_sel) + 33'(off_sel);
    hi = p[32:16];
    lo = $signed({1'b0, p[15:0]});
  end

  // round half up to q16.16 and saturate
  always_comb begin
    r      = 40'((acc_r + (72'sd1 <<< 31)) >>> 32);
    r_clip = 1'b0;
    r_sat  = r[31:0];
    if (r > 40'sd2147483647) begin
      r_sat  = 32'sh7fffffff;
      r_clip = 1'b1;
    end else if (r < -40'sd2147483648) begin
      r_sat  = 32'sh80000000;
      r_clip = 1'b1;
    end
  end

  assign load  = (st_r == B_DONE) && (!out_vld_r || out_pop);
  assign q_pop = (st_r == B_IDLE) && !q_empty;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      B_IDLE: if (!q_empty) st_nxt = q_data.is_wr ? B_WR : B_RD;
      B_WR:   st_nxt = B_IDLE;
      B_RD:   st_nxt = B_MUL;
      B_MUL:  st_nxt = B_ACC;
      B_ACC:  st_nxt = (k_r == 2'd3) ? B_FIN : B_RD;
      B_FIN:  st_nxt = (crd_r == 2'd2) ? B_DONE : B_RD;
      B_DONE: if (load) st_nxt = B_IDLE;
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= B_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (load) out_vld_r <= 1'b1;
      else if (out_pop && out_vld_r) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      B_IDLE: begin
        cur_r  <= q_data;
        k_r    <= 2'd0;
        crd_r  <= 2'd0;
        acc_r  <= '0;
        clip_r <= 1'b0;
      end
      B_MUL: begin
        prod_hi_r <= 52'(w_sel * hi);
        prod_lo_r <= 52'(w_sel * lo);
      end
      B_ACC: begin
        acc_r <= acc_r + (72'(prod_hi_r) <<< 16) + 72'(prod_lo_r);
        k_r   <= k_r + 2'd1;
      end
      B_FIN: begin
        case (crd_r)
          2'd0:    res_x_r <= r_sat;
          2'd1:    res_y_r <= r_sat;
          default: res_z_r <= r_sat;
        endcase
        clip_r <= clip_r | r_clip;
        crd_r  <= crd_r + 2'd1;
        acc_r  <= '0;
      end
      default: ;
    endcase
    if (load) begin
      out_x_r     <= res_x_r;
      out_y_r     <= res_y_r;
      out_z_r     <= res_z_r;
      out_clip_r  <= clip_r;
      out_slope_r <= cur_r.is_slope;
    end
  end

  assign out_empty    = !out_vld_r;
  assign out_result_x = out_x_r;
  assign out_result_y = out_y_r;
  assign out_result_z = out_z_r;
  assign out_clipped  = out_clip_r;
  assign out_is_slope = out_slope_r;

endmodule

[rtl/catmull_rom_spline_eval_top.sv]
// Catmull-Rom curve evaluator over a table of up to MAX_POINTS control points in signed
// q16.16. A write item loads one point into the table. A position or slope item passes
// the front end (segment select, square, cube, weights) and then the back end, which
// walks the four points of the segment for x, y and z through one table read port and
// one shared multiplier stage; the front end and a two-entry command queue let the
// front end prepare later items while the back end is busy. One result register lets
// the next item start while a result waits to be popped.
module catmull_rom_spline_eval_top #(
  parameter int unsigned MAX_POINTS = crse_pkg::MAX_POINTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [crse_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [crse_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_push,
  output logic                             in_full,
  input  logic [1:0]                       in_opcode,
  input  logic [3:0]                       in_point_index,
  input  logic signed [31:0]               in_point_x,
  input  logic signed [31:0]               in_point_y,
  input  logic signed [31:0]               in_point_z,
  input  logic [16:0]                      in_curve_param,
  output logic                             out_empty,
  input  logic                             out_pop,
  output logic signed [31:0]               out_result_x,
  output logic signed [31:0]               out_result_y,
  output logic signed [31:0]               out_result_z,
  output logic                             out_clipped,
  output logic                             out_is_slope
);
  import crse_pkg::*;

  logic [4:0]         point_count_r;
  logic signed [31:0] offset_x_r, offset_y_r, offset_z_r;

  logic q_push, q_full, q_pop, q_empty;
  cmd_t q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= 5'd4;
      offset_x_r    <= '0;
      offset_y_r    <= '0;
      offset_z_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POINT_COUNT: point_count_r <= cfg_wdata[4:0];
        REG_OFFSET_X:    offset_x_r    <= cfg_wdata;
        REG_OFFSET_Y:    offset_y_r    <= cfg_wdata;
        REG_OFFSET_Z:    offset_z_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  crse_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_opcode      (in_opcode),
    .in_point_index (in_point_index),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .in_point_z     (in_point_z),
    .in_curve_param (in_curve_param),
    .point_count    (point_count_r),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_wdata)
  );

  crse_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  crse_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .q_data       (q_rdata),
    .offset_x     (offset_x_r),
    .offset_y     (offset_y_r),
    .offset_z     (offset_z_r),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_result_x (out_result_x),
    .out_result_y (out_result_y),
    .out_result_z (out_result_z),
    .out_clipped  (out_clipped),
    .out_is_slope (out_is_slope)
  );

endmodule

[rtl/crse_checker.sv]
module crse_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_push,
  input logic               in_full,
  input logic [1:0]         in_opcode,
  input logic               out_empty,
  input logic               out_pop,
  input logic signed [31:0] out_result_x,
  input logic signed [31:0] out_result_y,
  input logic signed [31:0] out_result_z,
  input logic               out_clipped,
  input logic               out_is_slope
);
  import crse_pkg::*;

  // reset leaves both sides empty
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("not empty after reset");

  // a useful transfer keeps the input side busy next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full && (in_opcode == OP_WRITE || in_opcode == OP_POS ||
      in_opcode == OP_SLOPE)) |=> in_full)
    else $error("input side not busy after transfer");

  // a waiting result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_result_x) &&
      $stable(out_result_y) && $stable(out_result_z) && $stable(out_clipped) &&
      $stable(out_is_slope)))
    else $error("waiting result changed");

endmodule

bind catmull_rom_spline_eval_top crse_checker u_crse_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_push      (in_push),
  .in_full      (in_full),
  .in_opcode    (in_opcode),
  .out_empty    (out_empty),
  .out_pop      (out_pop),
  .out_result_x (out_result_x),
  .out_result_y (out_result_y),
  .out_result_z (out_result_z),
  .out_clipped  (out_clipped),
  .out_is_slope (out_is_slope)
);

[bench/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import crse_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 4'd5;
  localparam int DRAIN_CYCLES = 120;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [1:0]         op;
    logic [3:0]         idx;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [16:0]        t;
  } item_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               clipped;
    logic               is_slope;
  } point_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_push = 1'b0;
  logic in_full;
  logic [1:0] in_opcode = '0;
  logic [3:0] in_point_index = '0;
  logic signed [31:0] in_point_x = '0;
  logic signed [31:0] in_point_y = '0;
  logic signed [31:0] in_point_z = '0;
  logic [16:0] in_curve_param = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic signed [31:0] out_result_x;
  logic signed [31:0] out_result_y;
  logic signed [31:0] out_result_z;
  logic out_clipped;
  logic out_is_slope;

  catmull_rom_spline_eval_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_push(in_push), .in_full(in_full), .in_opcode(in_opcode),
    .in_point_index(in_point_index), .in_point_x(in_point_x),
    .in_point_y(in_point_y), .in_point_z(in_point_z),
    .in_curve_param(in_curve_param),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_result_x(out_result_x), .out_result_y(out_result_y),
    .out_result_z(out_result_z), .out_clipped(out_clipped),
    .out_is_slope(out_is_slope)
  );

  always #1 clk = ~clk;

  item_t pending_items[$];
  point_res_t expected_points[$];
  int errors = 0;
  int send_idle_pct = 0;
  int pop_stall_pct = 0;
  bit hold_off = 1'b0;
  int quiet_cycles = 0;

  // shadow of the block
  logic signed [31:0] table_pts [3][16];
  logic signed [31:0] owner_off [3];
  logic [4:0] point_count_reg;

  function automatic logic signed [31:0] blend_axis(input int ax, input int seg,
                                                    input longint w [4], inout bit clip);
    longint s_hi, s_lo, p, lo, r;
    s_hi = 0;
    s_lo = 0;
    for (int k = 0; k < 4; k++) begin
      p = longint'(table_pts[ax][seg + k]) + longint'(owner_off[ax]);
      lo = p & 64'hFFFF;
      s_hi += w[k] * (p >>> 16);
      s_lo += w[k] * lo;
    end
    r = (s_hi + ((s_lo + (64'sd1 <<< 31)) >>> 16)) >>> 16;
    if (r > 64'sd2147483647) begin
      r = 64'sd2147483647;
      clip = 1'b1;
    end else if (r < -64'sd2147483648) begin
      r = -64'sd2147483648;
      clip = 1'b1;
    end
    return r[31:0];
  endfunction

  function automatic point_res_t eval_curve(input item_t it);
    point_res_t res;
    longint n, segs, t, u, seg, lt, a, b, c, one;
    longint nw [4];
    longint w [4];
    bit clip;
    clip = 1'b0;
    one = 64'sd1 <<< 48;
    n = longint'(point_count_reg);
    if (n < 4) n = 4;
    if (n > longint'(MAX_POINTS_DEF)) n = longint'(MAX_POINTS_DEF);
    segs = n - 3;
    t = longint'(it.t);
    if (t > 65536) t = 65536;
    u = t * segs;
    seg = u >>> 16;
    if (seg > segs - 1) seg = segs - 1;
    lt = u - seg * 65536;
    a = lt * lt * lt;
    b = (lt * lt) <<< 16;
    c = lt <<< 32;
    if (it.op == OP_POS) begin
      nw[0] = -a + 2 * b - c;
      nw[1] = 3 * a - 5 * b + 2 * one;
      nw[2] = -3 * a + 4 * b + c;
      nw[3] = a - b;
    end else begin
      nw[0] = -3 * b + 4 * c - one;
      nw[1] = 9 * b - 10 * c;
      nw[2] = -9 * b + 8 * c + one;
      nw[3] = 3 * b - 2 * c;
    end
    for (int k = 0; k < 4; k++) w[k] = (nw[k] + 65536) >>> 17;
    res.x = blend_axis(0, int'(seg), w, clip);
    res.y = blend_axis(1, int'(seg), w, clip);
    res.z = blend_axis(2, int'(seg), w, clip);
    res.clipped = clip;
    res.is_slope = (it.op == OP_SLOPE);
    return res;
  endfunction

  function automatic void apply_item(input item_t it);
    if (it.op == OP_WRITE) begin
      table_pts[0][it.idx] = it.px;
      table_pts[1][it.idx] = it.py;
      table_pts[2][it.idx] = it.pz;
    end else if (it.op != OP_UNUSED) begin
      expected_points.insert(expected_points.size(), eval_curve(it));
    end
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(32'h3FFFF)) - 32'sh20000;
      default: return $urandom;
    endcase
  endfunction

  function automatic item_t rand_item();
    item_t it;
    int r;
    r = $urandom_range(99);
    it.idx = 4'($urandom_range(15));
    it.px = rand_coord();
    it.py = rand_coord();
    it.pz = rand_coord();
    if (r < 25) it.op = OP_WRITE;
    else if (r < 60) it.op = OP_POS;
    else if (r < 95) it.op = OP_SLOPE;
    else it.op = OP_UNUSED;
    case ($urandom_range(9))
      0: it.t = 17'd0;
      1: it.t = 17'd65536;
      2: it.t = 17'($urandom_range(17'h1FFFF));
      default: it.t = 17'($urandom_range(65536));
    endcase
    return it;
  endfunction

  function automatic item_t make_item(input logic [1:0] op, input logic [3:0] idx,
                                      input logic signed [31:0] v, input logic [16:0] t);
    item_t it;
    it.op = op;
    it.idx = idx;
    it.px = v;
    it.py = ~v;
    it.pz = v ^ 32'h5A5A5A5A;
    it.t = t;
    return it;
  endfunction

  function automatic void queue_item(input item_t it);
    pending_items.insert(pending_items.size(), it);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_POINT_COUNT: point_count_reg = val[4:0];
      REG_OFFSET_X: owner_off[0] = val;
      REG_OFFSET_Y: owner_off[1] = val;
      REG_OFFSET_Z: owner_off[2] = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || in_push || expected_points.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    item_t it;
    bit next_push;
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      next_push = in_push;
      if (in_push && !in_full) begin
        it.op = in_opcode;
        it.idx = in_point_index;
        it.px = in_point_x;
        it.py = in_point_y;
        it.pz = in_point_z;
        it.t = in_curve_param;
        apply_item(it);
        next_push = 1'b0;
      end
      if (!next_push && !hold_off && pending_items.size() != 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        it = pending_items.pop_front();
        in_opcode <= it.op;
        in_point_index <= it.idx;
        in_point_x <= it.px;
        in_point_y <= it.py;
        in_point_z <= it.pz;
        in_curve_param <= it.t;
        next_push = 1'b1;
      end
      in_push <= next_push;
    end
  end

  // monitor
  always @(posedge clk) begin
    point_res_t e;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_points.size() == 0) begin
          $error("result transfer with nothing expected");
          errors++;
        end else begin
          e = expected_points.pop_front();
          if (out_result_x !== e.x) begin
            $error("result_x expected %0d got %0d", e.x, out_result_x); errors++;
          end
          if (out_result_y !== e.y) begin
            $error("result_y expected %0d got %0d", e.y, out_result_y); errors++;
          end
          if (out_result_z !== e.z) begin
            $error("result_z expected %0d got %0d", e.z, out_result_z); errors++;
          end
          if (out_clipped !== e.clipped) begin
            $error("clipped expected %0d got %0d", e.clipped, out_clipped); errors++;
          end
          if (out_is_slope !== e.is_slope) begin
            $error("is_slope expected %0d got %0d", e.is_slope, out_is_slope); errors++;
          end
        end
      end
      out_pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || !rst_n || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int idle_modes [4][2];
    logic [31:0] cfg_sets [8][4];
    idle_modes = '{'{0, 0}, '{75, 0}, '{0, 75}, '{12, 12}};
    cfg_sets = '{
      '{32'd16, 32'h7FFFFFFF, 32'h80000000, 32'h00010000},
      '{32'd4, 32'h80000000, 32'h7FFFFFFF, 32'hFFFF0000},
      '{32'd0, 32'h0, 32'h0, 32'h0},
      '{32'd31, 32'h00008000, 32'hFFFFFFFF, 32'h40000000},
      '{32'd7, 32'h0, 32'h0, 32'h0},
      '{32'd17, 32'h12345678, 32'h0, 32'hC0000000},
      '{32'd10, 32'h0, 32'h00001000, 32'h0},
      '{32'd16, 32'h0, 32'h0, 32'h0}};
    point_count_reg = 5'd4;
    owner_off = '{0, 0, 0};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: load every slot, then extremes of the parameter and each opcode
    for (int i = 0; i < 16; i++)
      queue_item(make_item(OP_WRITE, 4'(i),
        (i % 3 == 0) ? 32'sh7FFFFFFF : (i % 3 == 1) ? 32'sh80000000 : 32'sh00010000 * i,
        17'd0));
    queue_item(make_item(OP_POS, 4'd0, 32'sd0, 17'd0));
    queue_item(make_item(OP_POS, 4'd0, 32'sd0, 17'd65536));
    queue_item(make_item(OP_SLOPE, 4'd0, 32'sd0, 17'd0));
    queue_item(make_item(OP_SLOPE, 4'd0, 32'sd0, 17'h1FFFF));
    queue_item(make_item(OP_POS, 4'd0, 32'sd0, 17'h1FFFF));
    queue_item(make_item(OP_UNUSED, 4'd15, 32'sd0, 17'd32768));
    queue_item(make_item(OP_POS, 4'd0, 32'sd0, 17'd32768));
    drain();
    write_reg(REG_NONE, 32'hFFFFFFFF);

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_POINT_COUNT, cfg_sets[ph][0]);
      write_reg(REG_OFFSET_X, cfg_sets[ph][1]);
      write_reg(REG_OFFSET_Y, cfg_sets[ph][2]);
      write_reg(REG_OFFSET_Z, cfg_sets[ph][3]);
      send_idle_pct = idle_modes[ph % 4][0];
      pop_stall_pct = idle_modes[ph % 4][1];
      for (int i = 0; i < 160; i++) queue_item(rand_item());
      if (ph == 2) begin
        // sender holds off until every result is back
        while (pending_items.size() > 80) @(posedge clk);
        hold_off = 1'b1;
        while (in_push || expected_points.size() != 0) @(posedge clk);
        hold_off = 1'b0;
      end
      drain();
    end

    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
